// File: sv/erwl_pkg.sv
// ----------------------------------------------------------------------------
// erwl_pkg: shared types and constants of the record wear leveler
// Item payloads, stored page record, shared adder request/response and
// result codes.
// ----------------------------------------------------------------------------
package erwl_pkg;

  // Image size and register reset value
  localparam int unsigned PAGE_COUNT_DEF  = 128;
  localparam logic [31:0] ERASE_LIMIT_RST = 32'd100000;
  localparam int unsigned FIRST_DATA_PAGE = 2;

  // Result codes
  localparam logic [2:0] OUT_BOTH_INVALID = 3'd0;
  localparam logic [2:0] OUT_ONE_REPAIRED = 3'd1;
  localparam logic [2:0] OUT_BOTH_VALID   = 3'd2;
  localparam logic [2:0] OUT_SAVED        = 3'd3;
  localparam logic [2:0] OUT_SAVED_MOVED  = 3'd4;

  // Item function codes
  localparam logic FUNC_INIT = 1'b0;
  localparam logic FUNC_SAVE = 1'b1;

  typedef struct packed {
    logic        func;
    logic [31:0] total_value;
    logic [31:0] subtotal_value;
    logic [31:0] subtotal_two_value;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  outcome;
    logic [6:0]  pair_first_page;
    logic [31:0] erase_count;
    logic        directory_written;
  } out_item_t;

  // One stored data page
  typedef struct packed {
    logic [31:0] erases;
    logic [31:0] total;
    logic [31:0] subtotal;
    logic [31:0] subtotal_two;
  } page_rec_t;

  // Shared adder operations
  typedef enum logic {
    ALU_INC,
    ALU_LT
  } alu_op_e;

  typedef struct packed {
    alu_op_e     op;
    logic [31:0] a;
    logic [31:0] b;
  } alu_req_t;

  typedef struct packed {
    logic [31:0] sum;
    logic        lt;
  } alu_rsp_t;

endpackage

// File: sv/erwl_alu.sv
// ----------------------------------------------------------------------------
// erwl_alu: shared 32-bit adder
// One carry chain serves both the increment and the unsigned less-than.
// ----------------------------------------------------------------------------
module erwl_alu
  import erwl_pkg::*;
(
  input  alu_req_t req_i,
  output alu_rsp_t rsp_o
);

  logic [31:0] b_op;
  logic [32:0] sum;

  // Select second operand: zero for increment, inverted b for compare
  always_comb begin
    case (req_i.op)
      ALU_INC: b_op = 32'd0;
      ALU_LT:  b_op = ~req_i.b;
      default: b_op = 32'd0;
    endcase
  end

  // Add with carry in; carry out set means a >= b on compare
  assign sum = {1'b0, req_i.a} + {1'b0, b_op} + 33'd1;

  assign rsp_o.sum = sum[31:0];
  assign rsp_o.lt  = ~sum[32];

endmodule

// File: sv/erwl_page_mem.sv
// ----------------------------------------------------------------------------
// erwl_page_mem: data page store
// Single-port page record memory with registered read data.
// ----------------------------------------------------------------------------
module erwl_page_mem
  import erwl_pkg::*;
#(
  parameter int unsigned PAGE_COUNT = PAGE_COUNT_DEF,
  parameter int unsigned AW         = $clog2(PAGE_COUNT)
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] addr_i,
  input  page_rec_t     wdata_i,
  output page_rec_t     rdata_o
);

  page_rec_t mem_q [PAGE_COUNT];
  page_rec_t rdata_q;

  // Write or read one page per cycle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/eeprom_record_wear_leveler.sv
// Init: directory repaired on input transfer; result loaded in S_FIN, then S_IDLE.
// Save: states S_RD1 to S_WR2, then S_FIN (two page reads and two
//   page writes on the single-port page memory, three passes of the shared adder).
// A result register lets the next item in while a result waits.
// Reset clears directory and page valid bits, sets erase_limit (100000) at once;
//   no clearing pass over the page memory.
// ----------------------------------------------------------------------------
// eeprom_record_wear_leveler: page-pair wear-leveling record store
// Keeps a duplicated directory and even/odd data page pairs, repairs the
// directory on init and writes records to the active pair on save.
// ----------------------------------------------------------------------------
module eeprom_record_wear_leveler
  import erwl_pkg::*;
#(
  parameter int unsigned PAGE_COUNT = PAGE_COUNT_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_item_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_item_t   out_data_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [31:0] cfg_data_i
);

  localparam int unsigned PW  = $clog2(PAGE_COUNT);
  localparam int unsigned PW1 = PW + 1;
  localparam int unsigned MW  = (PW > 7) ? PW : 7;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD1,
    S_RD2,
    S_CMP,
    S_INC,
    S_LIM,
    S_WR1,
    S_WR2,
    S_FIN
  } state_e;

  state_e          state_q;
  logic [31:0]     limit_q;
  logic [PW-1:0]   dir1_q, dir2_q;
  logic            dir1_ok_q, dir2_ok_q;
  logic [PAGE_COUNT-1:0] page_ok_q;
  in_item_t        item_q;
  logic [PW-1:0]   first_q;
  logic [31:0]     e1_q, t1_q, cnt_q;
  logic            moved_q;
  logic [2:0]      res_outcome_q;
  logic [PW-1:0]   res_page_q;
  logic            res_dirw_q;
  logic            out_valid_q;
  out_item_t       out_q;

  logic [PW-1:0]   second;
  logic [PW-1:0]   dir_max;
  logic [31:0]     e2_sel, t2_sel;
  logic [MW-1:0]   page_ext;
  alu_req_t        alu_req;
  alu_rsp_t        alu_rsp;
  logic            mem_we;
  logic [PW-1:0]   mem_addr;
  page_rec_t       mem_wdata, mem_rdata;

  // First page of a pair that fits in the image, else the first data pair
  function automatic logic [PW-1:0] fit_pair(input logic [PW1-1:0] id);
    logic [PW1-1:0] f;
    if (id < PW1'(FIRST_DATA_PAGE)) begin
      f = PW1'(FIRST_DATA_PAGE);
    end else begin
      f = id & ~PW1'(1);
    end
    if ((f + PW1'(1)) >= PW1'(PAGE_COUNT)) begin
      f = PW1'(FIRST_DATA_PAGE);
    end
    return f[PW-1:0];
  endfunction

  erwl_alu u_alu (
    .req_i (alu_req),
    .rsp_o (alu_rsp)
  );

  erwl_page_mem #(
    .PAGE_COUNT (PAGE_COUNT),
    .AW         (PW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  assign second  = first_q + PW'(1);
  assign dir_max = (dir1_q > dir2_q) ? dir1_q : dir2_q;

  // Second page falls back to a copy of the first when invalid
  assign e2_sel = page_ok_q[second] ? mem_rdata.erases : e1_q;
  assign t2_sel = page_ok_q[second] ? mem_rdata.total  : t1_q;

  // Drive shared adder and page memory port from the sequencer state
  always_comb begin
    alu_req   = '{op: ALU_INC, a: cnt_q, b: 32'd0};
    mem_we    = 1'b0;
    mem_addr  = first_q;
    mem_wdata = '{erases:       cnt_q,
                  total:        item_q.total_value,
                  subtotal:     item_q.subtotal_value,
                  subtotal_two: item_q.subtotal_two_value};
    case (state_q)
      S_RD2: mem_addr = second;
      S_CMP: alu_req = '{op: ALU_LT, a: t1_q, b: t2_sel};
      S_LIM: alu_req = '{op: ALU_LT, a: cnt_q, b: limit_q};
      S_WR1: mem_we = 1'b1;
      S_WR2: begin
        mem_we   = 1'b1;
        mem_addr = second;
      end
      default: ;
    endcase
  end

  // Sequencer, directory and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      limit_q       <= ERASE_LIMIT_RST;
      dir1_q        <= '0;
      dir2_q        <= '0;
      dir1_ok_q     <= 1'b0;
      dir2_ok_q     <= 1'b0;
      page_ok_q     <= '0;
      item_q        <= '0;
      first_q       <= '0;
      e1_q          <= '0;
      t1_q          <= '0;
      cnt_q         <= '0;
      moved_q       <= 1'b0;
      res_outcome_q <= OUT_BOTH_INVALID;
      res_page_q    <= '0;
      res_dirw_q    <= 1'b0;
      out_valid_q   <= 1'b0;
      out_q         <= '0;
    end else begin
      if (cfg_valid_i) begin
        limit_q <= cfg_data_i;
      end
      // Drop the result after its transfer unless a new one loads now
      if (out_valid_q && out_ready_i && (state_q != S_FIN)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            item_q <= in_data_i;
            cnt_q  <= 32'd0;
            if (in_data_i.func == FUNC_SAVE) begin
              first_q <= fit_pair({1'b0, dir_max});
              state_q <= S_RD1;
            end else begin
              // Repair directory
              if (!dir1_ok_q && !dir2_ok_q) begin
                dir1_q        <= PW'(FIRST_DATA_PAGE);
                dir2_q        <= PW'(FIRST_DATA_PAGE);
                res_outcome_q <= OUT_BOTH_INVALID;
                res_page_q    <= PW'(FIRST_DATA_PAGE);
                res_dirw_q    <= 1'b1;
              end else if (dir1_ok_q != dir2_ok_q) begin
                if (dir1_ok_q) begin
                  dir2_q     <= dir1_q;
                  res_page_q <= dir1_q;
                end else begin
                  dir1_q     <= dir2_q;
                  res_page_q <= dir2_q;
                end
                res_outcome_q <= OUT_ONE_REPAIRED;
                res_dirw_q    <= 1'b1;
              end else begin
                res_outcome_q <= OUT_BOTH_VALID;
                res_page_q    <= dir_max;
                res_dirw_q    <= 1'b0;
              end
              dir1_ok_q <= 1'b1;
              dir2_ok_q <= 1'b1;
              state_q   <= S_FIN;
            end
          end
        end
        S_RD1: state_q <= S_RD2;
        S_RD2: begin
          // Capture first page, zero when invalid
          e1_q    <= page_ok_q[first_q] ? mem_rdata.erases : 32'd0;
          t1_q    <= page_ok_q[first_q] ? mem_rdata.total  : 32'd0;
          state_q <= S_CMP;
        end
        S_CMP: begin
          // Take the count from the page with the larger total
          cnt_q   <= alu_rsp.lt ? e2_sel : e1_q;
          moved_q <= 1'b0;
          state_q <= S_INC;
        end
        S_INC: begin
          cnt_q   <= alu_rsp.sum;
          state_q <= S_LIM;
        end
        S_LIM: begin
          // Retire pair at the limit
          if (!alu_rsp.lt) begin
            first_q <= fit_pair({1'b0, first_q} + PW1'(2));
            cnt_q   <= 32'd0;
            moved_q <= 1'b1;
          end
          state_q <= S_WR1;
        end
        S_WR1: begin
          page_ok_q[first_q] <= 1'b1;
          state_q            <= S_WR2;
        end
        S_WR2: begin
          page_ok_q[second] <= 1'b1;
          res_outcome_q     <= moved_q ? OUT_SAVED_MOVED : OUT_SAVED;
          res_page_q        <= first_q;
          if (first_q != dir1_q) begin
            dir1_q     <= first_q;
            dir2_q     <= first_q;
            dir1_ok_q  <= 1'b1;
            dir2_ok_q  <= 1'b1;
            res_dirw_q <= 1'b1;
          end else begin
            res_dirw_q <= 1'b0;
          end
          state_q <= S_FIN;
        end
        S_FIN: begin
          // Load result once the output register is free
          if (!out_valid_q || out_ready_i) begin
            out_valid_q             <= 1'b1;
            out_q.outcome           <= res_outcome_q;
            out_q.pair_first_page   <= page_ext[6:0];
            out_q.erase_count       <= cnt_q;
            out_q.directory_written <= res_dirw_q;
            state_q                 <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign page_ext    = MW'(res_page_q);
  assign in_ready_o  = (state_q == S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  // Block is busy right after taking an item
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input taken while an item is in progress");

  // A move always restarts the erase count
  a_moved_count_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.outcome == OUT_SAVED_MOVED) |-> out_data_o.erase_count == 32'd0)
    else $error("moved pair with nonzero erase count");

  // Init results carry no erase count
  a_init_count_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.outcome == OUT_BOTH_INVALID ||
                     out_data_o.outcome == OUT_ONE_REPAIRED ||
                     out_data_o.outcome == OUT_BOTH_VALID))
    |-> out_data_o.erase_count == 32'd0)
    else $error("init result with nonzero erase count");

  // Directory repair always rewrites the directory
  a_init_dir_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.outcome == OUT_BOTH_INVALID ||
                     out_data_o.outcome == OUT_ONE_REPAIRED))
    |-> out_data_o.directory_written)
    else $error("directory repair without rewrite");
`endif

endmodule

// File: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench of the record wear leveler
// Walks a short directed table, then random phases with changing erase
// limits and sender/receiver idling. Every result is compared with a typed
// expectation or the output of a local model of the directory and page-pair store.
// ----------------------------------------------------------------------------
module tb_top;
  import erwl_pkg::*;

  localparam int unsigned STALL_LIMIT  = 4000;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned PHASE_ITEMS  = 230;
  localparam int unsigned PHASES       = 8;

  typedef enum logic {
    ROW_ITEM,
    ROW_LIMIT
  } row_kind_e;

  typedef struct packed {
    row_kind_e   kind;
    in_item_t    item;
    logic        known;
    out_item_t   result;
    logic [31:0] limit;
  } stim_row_t;

  logic        clk_i;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  in_item_t    in_data_i   = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  out_item_t   out_data_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [31:0] cfg_data_i  = '0;

  // Local copy of the store
  logic [31:0] limit_copy = ERASE_LIMIT_RST;
  int unsigned dir_first_id  = 0;
  int unsigned dir_second_id = 0;
  bit          dir_first_ok  = 1'b0;
  bit          dir_second_ok = 1'b0;
  bit          page_valid [PAGE_COUNT_DEF];
  page_rec_t   page_mem   [PAGE_COUNT_DEF];

  out_item_t   record_q [$];
  stim_row_t   rows     [$];

  int unsigned idle_pct  = 0;
  int unsigned stall_pct = 0;
  int unsigned fails     = 0;
  int unsigned items_sent      = 0;
  int unsigned results_checked = 0;
  int unsigned pair_moves      = 0;
  int unsigned pair_wraps      = 0;
  int unsigned limit_writes    = 0;
  int unsigned quiet_cycles    = 0;

  eeprom_record_wear_leveler u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // First page of a pair that fits in the image, falling back to page 2
  function automatic int unsigned pair_base(int unsigned id);
    int unsigned first;
    if (id < FIRST_DATA_PAGE) id = FIRST_DATA_PAGE;
    first = id & ~32'd1;
    if (first + 1 >= PAGE_COUNT_DEF) first = FIRST_DATA_PAGE;
    return first;
  endfunction

  // Apply one item to the local store and return its result
  function automatic out_item_t predict_record(in_item_t it);
    out_item_t   r;
    int unsigned first, second;
    logic [31:0] e1, t1, e2, t2, cnt;
    logic        moved;
    r = '0;
    if (it.func == FUNC_INIT) begin
      if (!dir_first_ok && !dir_second_ok) begin
        dir_first_id  = FIRST_DATA_PAGE;
        dir_second_id = FIRST_DATA_PAGE;
        dir_first_ok  = 1'b1;
        dir_second_ok = 1'b1;
        r.outcome           = OUT_BOTH_INVALID;
        r.pair_first_page   = 7'(FIRST_DATA_PAGE);
        r.directory_written = 1'b1;
      end else if (dir_first_ok != dir_second_ok) begin
        if (dir_first_ok) dir_second_id = dir_first_id;
        else dir_first_id = dir_second_id;
        dir_first_ok  = 1'b1;
        dir_second_ok = 1'b1;
        r.outcome           = OUT_ONE_REPAIRED;
        r.pair_first_page   = dir_first_id[6:0];
        r.directory_written = 1'b1;
      end else begin
        r.outcome = OUT_BOTH_VALID;
        r.pair_first_page = (dir_first_id > dir_second_id) ? dir_first_id[6:0]
                                                           : dir_second_id[6:0];
      end
    end else begin
      first  = pair_base((dir_first_id > dir_second_id) ? dir_first_id : dir_second_id);
      second = first + 1;
      e1 = '0;
      t1 = '0;
      if (page_valid[first]) begin
        e1 = page_mem[first].erases;
        t1 = page_mem[first].total;
      end
      if (page_valid[second]) begin
        e2 = page_mem[second].erases;
        t2 = page_mem[second].total;
      end else begin
        e2 = e1;
        t2 = t1;
      end
      cnt   = ((t1 < t2) ? e2 : e1) + 32'd1;
      moved = 1'b0;
      // Retire the pair at the limit and restart the count
      if (cnt >= limit_copy) begin
        first  = pair_base(second + 1);
        second = first + 1;
        cnt    = '0;
        moved  = 1'b1;
        pair_moves++;
        if (first == FIRST_DATA_PAGE) pair_wraps++;
      end
      page_valid[first]  = 1'b1;
      page_valid[second] = 1'b1;
      page_mem[first]  = page_rec_t'{cnt, it.total_value, it.subtotal_value,
                                     it.subtotal_two_value};
      page_mem[second] = page_mem[first];
      if (first != dir_first_id) begin
        dir_first_id  = first;
        dir_second_id = first;
        dir_first_ok  = 1'b1;
        dir_second_ok = 1'b1;
        r.directory_written = 1'b1;
      end
      r.outcome         = moved ? OUT_SAVED_MOVED : OUT_SAVED;
      r.pair_first_page = first[6:0];
      r.erase_count     = cnt;
    end
    return r;
  endfunction

  function automatic stim_row_t item_row(logic func, logic [31:0] tot, logic [31:0] sub,
                                         logic [31:0] sub2, logic known, out_item_t res);
    stim_row_t row;
    row = '0;
    row.kind   = ROW_ITEM;
    row.item   = in_item_t'{func, tot, sub, sub2};
    row.known  = known;
    row.result = res;
    return row;
  endfunction

  function automatic stim_row_t limit_row(logic [31:0] v);
    stim_row_t row;
    row = '0;
    row.kind  = ROW_LIMIT;
    row.limit = v;
    return row;
  endfunction

  // Word with a bias toward the all-zero and all-one extremes
  function automatic logic [31:0] rand_word();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  // Offer one record, hold it until the transfer, then log its result
  task automatic send_record(in_item_t it, logic known, out_item_t res);
    out_item_t predicted;
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (!in_ready_o);
    predicted = predict_record(it);
    record_q.push_back(known ? res : predicted);
    items_sent++;
  endtask

  // Write the erase limit once every pending result has drained
  task automatic write_erase_limit(logic [31:0] v);
    in_valid_i <= 1'b0;
    while (record_q.size() != 0) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    limit_copy = v;
    limit_writes++;
  endtask

  // Receiver stall pattern
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= stall_pct);
  end

  // Compare every result transfer with the oldest expectation
  always @(posedge clk_i) begin : check_results
    out_item_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (record_q.size() == 0) begin
        $error("unexpected result: %h", out_data_o);
        fails++;
      end else begin
        want = record_q.pop_front();
        results_checked++;
        if (out_data_o.outcome !== want.outcome) begin
          $error("outcome: expected %0d got %0d", want.outcome, out_data_o.outcome);
          fails++;
        end
        if (out_data_o.pair_first_page !== want.pair_first_page) begin
          $error("pair_first_page: expected %0d got %0d", want.pair_first_page,
                 out_data_o.pair_first_page);
          fails++;
        end
        if (out_data_o.erase_count !== want.erase_count) begin
          $error("erase_count: expected %0d got %0d", want.erase_count,
                 out_data_o.erase_count);
          fails++;
        end
        if (out_data_o.directory_written !== want.directory_written) begin
          $error("directory_written: expected %0d got %0d", want.directory_written,
                 out_data_o.directory_written);
          fails++;
        end
      end
    end
  end

  // End the run when no transfer happens for too long
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o) || !rst_ni) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    logic [31:0] phase_limit [PHASES];
    int unsigned idle_set  [4];
    int unsigned stall_set [4];
    in_item_t    it;

    idle_set  = '{0, 74, 0, 25};
    stall_set = '{0, 0, 74, 25};
    phase_limit = '{32'd1, 32'hFFFF_FFFF, 32'd2, 32'd3, 32'd1,
                    32'($urandom_range(2, 12)), 32'd5, ERASE_LIMIT_RST};

    // Directed table; typed results before the first limit row hold at the reset limit of 100000
    rows.push_back(item_row(FUNC_INIT, '0, '0, '0, 1'b1,
                            out_item_t'{OUT_BOTH_INVALID, 7'd2, 32'd0, 1'b1}));
    rows.push_back(item_row(FUNC_INIT, '1, '1, '1, 1'b1,
                            out_item_t'{OUT_BOTH_VALID, 7'd2, 32'd0, 1'b0}));
    rows.push_back(item_row(FUNC_SAVE, '0, '0, '0, 1'b1,
                            out_item_t'{OUT_SAVED, 7'd2, 32'd1, 1'b0}));
    rows.push_back(item_row(FUNC_SAVE, '1, '1, '1, 1'b1,
                            out_item_t'{OUT_SAVED, 7'd2, 32'd2, 1'b0}));
    rows.push_back(item_row(FUNC_SAVE, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA,
                            1'b0, '0));
    rows.push_back(item_row(FUNC_SAVE, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555,
                            1'b0, '0));
    rows.push_back(item_row(FUNC_INIT, '0, '0, '0, 1'b1,
                            out_item_t'{OUT_BOTH_VALID, 7'd2, 32'd0, 1'b0}));
    // Smallest limit: every save retires its pair
    rows.push_back(limit_row(32'd1));
    rows.push_back(item_row(FUNC_SAVE, 32'd1, 32'd2, 32'd3, 1'b1,
                            out_item_t'{OUT_SAVED_MOVED, 7'd4, 32'd0, 1'b1}));
    rows.push_back(item_row(FUNC_SAVE, 32'h8000_0000, '0, '1, 1'b1,
                            out_item_t'{OUT_SAVED_MOVED, 7'd6, 32'd0, 1'b1}));
    rows.push_back(item_row(FUNC_INIT, '1, '0, '1, 1'b1,
                            out_item_t'{OUT_BOTH_VALID, 7'd6, 32'd0, 1'b0}));
    // Largest limit: the pair stays put
    rows.push_back(limit_row(32'hFFFF_FFFF));
    rows.push_back(item_row(FUNC_SAVE, 32'd7, 32'd8, 32'd9, 1'b1,
                            out_item_t'{OUT_SAVED, 7'd6, 32'd1, 1'b0}));
    rows.push_back(item_row(FUNC_SAVE, 32'd6, 32'hFFFF_0000, 32'h0000_FFFF, 1'b0, '0));
    rows.push_back(limit_row(32'd2));
    rows.push_back(item_row(FUNC_SAVE, '0, '1, '0, 1'b0, '0));
    rows.push_back(item_row(FUNC_SAVE, '1, '0, '1, 1'b0, '0));
    rows.push_back(item_row(FUNC_SAVE, 32'h0F0F_0F0F, 32'hF0F0_F0F0, 32'h0F0F_0F0F,
                            1'b0, '0));
    rows.push_back(item_row(FUNC_INIT, '0, '0, '0, 1'b0, '0));
    rows.push_back(limit_row(ERASE_LIMIT_RST));

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Walk the directed table
    foreach (rows[i]) begin
      if (rows[i].kind == ROW_LIMIT) write_erase_limit(rows[i].limit);
      else send_record(rows[i].item, rows[i].known, rows[i].result);
    end

    // Random phases: mostly saves, one limit and one idling mode per phase
    for (int p = 0; p < PHASES; p++) begin
      write_erase_limit(phase_limit[p]);
      idle_pct  = idle_set[p % 4];
      stall_pct = stall_set[p % 4];
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        it.func               = ($urandom_range(99) < 15) ? FUNC_INIT : FUNC_SAVE;
        it.total_value        = rand_word();
        it.subtotal_value     = rand_word();
        it.subtotal_two_value = rand_word();
        send_record(it, 1'b0, '0);
      end
    end

    // Drain and report
    in_valid_i <= 1'b0;
    idle_pct  = 0;
    stall_pct = 0;
    while (record_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("summary: %0d records sent, %0d results checked, %0d limit writes",
             items_sent, results_checked, limit_writes);
    $display("summary: %0d pair moves, %0d wraps back to the first data pair",
             pair_moves, pair_wraps);
    if (fails == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
